// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the decoder's byte collector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ETFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ETFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/etfd_pkg.sv =====
// Package: frame layout, header codes, scale factors and shared types
`default_nettype none

package etfd_pkg;

	localparam int FRAME_BYTES = 27;
	localparam int LAST_POS    = FRAME_BYTES - 1;
	localparam int NUM_READ    = 10;
	localparam int FIRST_READ  = 6;

	localparam logic [7:0] HDR_SYNC0   = 8'h80;
	localparam logic [7:0] HDR_SYNC1   = 8'h8F;
	localparam logic [7:0] HDR_SYNC2   = 8'hEA;
	localparam logic [7:0] HDR_LENGTH  = 8'h16;
	localparam logic [7:0] HDR_SERVICE = 8'h50;

	// reading slots in frame order
	localparam int RD_RPM  = 0;
	localparam int RD_MAP  = 1;
	localparam int RD_TPS  = 2;
	localparam int RD_CLT  = 3;
	localparam int RD_IAT  = 4;
	localparam int RD_O2   = 5;
	localparam int RD_SPK  = 6;
	localparam int RD_INJ1 = 7;
	localparam int RD_INJ2 = 8;
	localparam int RD_BATT = 9;

	// round(factor * 65536) for the non power-of-two factors
	localparam int SCALE_TPS  = 98;
	localparam int SCALE_O2   = 315;
	localparam int SCALE_INJ  = 66;
	localparam int SCALE_BATT = 410;

	localparam logic [32:0] TEMP_OFFSET_Q = 33'(40 * 65536);

	typedef logic [15:0] raw_t;

	typedef struct packed {
		logic                      valid;
		logic [NUM_READ-1:0][15:0] raw;
	} frame_t;

endpackage

`default_nettype wire

// ===== rtl/core/etfd_collect.sv =====
// Byte collector: frame store, header check and the frame stage register
`default_nettype none
`include "assert_macros.svh"

module etfd_collect
	import etfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       drained,
	input  wire logic       take,
	output frame_t          frame_s1
);

	logic [4:0] pos_q;
	logic       disc_q;
	logic [7:0] store_q [0:FRAME_BYTES-1];

	logic                      frame_valid_s1;
	logic [NUM_READ-1:0][15:0] frame_raw_s1;

	logic       accept;
	logic       write_en;
	logic [4:0] pos_sat;
	logic       last_byte;
	logic       hdr_ok;
	logic       frame_good;
	logic [NUM_READ-1:0][15:0] raw_w;

	assign frame_s1 = '{valid: frame_valid_s1, raw: frame_raw_s1};

	assign accept   = in_valid && !in_stall;
	// block only while a finished frame cannot move on
	assign in_stall = frame_valid_s1 && !take;

	always_comb begin
		pos_sat    = (pos_q >= 5'(LAST_POS)) ? 5'(LAST_POS) : pos_q;
		write_en   = accept && !drained && !disc_q;
		last_byte  = (pos_sat == 5'(LAST_POS));
		hdr_ok     = (store_q[0] == HDR_SYNC0) && (store_q[1] == HDR_SYNC1) &&
			(store_q[2] == HDR_SYNC2) && (store_q[3] == HDR_LENGTH) &&
			(store_q[4] == HDR_SERVICE);
		frame_good = write_en && last_byte && hdr_ok;
	end

	// big-endian pairs; the trailing byte is never used, so no bypass
	always_comb begin
		for (int k = 0; k < NUM_READ; k++) begin
			raw_w[k] = {store_q[FIRST_READ + 2*k], store_q[FIRST_READ + 2*k + 1]};
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			store_q[pos_sat] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			disc_q         <= 1'b0;
			frame_valid_s1 <= 1'b0;
		end else begin
			if (accept && drained) begin
				disc_q <= 1'b0;
			end else if (write_en) begin
				if (last_byte) begin
					pos_q <= '0;
					// bad header: drop until the buffer is flushed
					disc_q <= !hdr_ok;
				end else begin
					pos_q <= pos_sat + 5'd1;
				end
			end
			if (frame_good) begin
				frame_valid_s1 <= 1'b1;
			end else if (take) begin
				frame_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_good) begin
			frame_raw_s1 <= raw_w;
		end
	end

	`ETFD_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= 5'(LAST_POS))
	`ETFD_ASSERT_NXT(a_drain_ends, accept && drained, !disc_q)
	`ETFD_ASSERT_NXT(a_disc_holds, accept && !drained && disc_q, $stable(pos_q) && disc_q)
	`ETFD_ASSERT_NXT(a_frame_held, frame_valid_s1 && !take,
		frame_valid_s1 && $stable(frame_raw_s1))

endmodule

`default_nettype wire

// ===== rtl/core/etfd_scale.sv =====
// Fixed-point scaling of the ten readings into the result register
`default_nettype none

module etfd_scale
	import etfd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire frame_t       frame_s1,
	output logic              take,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [29:0]       engine_speed,
	output logic [23:0]       manifold_pressure,
	output logic [22:0]       throttle_position,
	output logic signed [32:0] coolant_temp,
	output logic signed [32:0] intake_air_temp,
	output logic [24:0]       oxygen_sensor,
	output logic [30:0]       spark_advance,
	output logic [22:0]       fuel_pulse_one,
	output logic [22:0]       fuel_pulse_two,
	output logic [24:0]       battery_voltage
);

	raw_t        r_rpm, r_map, r_tps, r_clt, r_iat, r_o2, r_spk, r_inj1, r_inj2, r_batt;
	logic [32:0] clt_w, iat_w;

	assign take = frame_s1.valid && (!out_valid || !out_stall);

	always_comb begin
		r_rpm  = frame_s1.raw[RD_RPM];
		r_map  = frame_s1.raw[RD_MAP];
		r_tps  = frame_s1.raw[RD_TPS];
		r_clt  = frame_s1.raw[RD_CLT];
		r_iat  = frame_s1.raw[RD_IAT];
		r_o2   = frame_s1.raw[RD_O2];
		r_spk  = frame_s1.raw[RD_SPK];
		r_inj1 = frame_s1.raw[RD_INJ1];
		r_inj2 = frame_s1.raw[RD_INJ2];
		r_batt = frame_s1.raw[RD_BATT];
		// wraps to two's complement below forty degrees
		clt_w  = {1'b0, r_clt, 16'b0} - TEMP_OFFSET_Q;
		iat_w  = {1'b0, r_iat, 16'b0} - TEMP_OFFSET_Q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			engine_speed      <= {r_rpm, 14'b0};
			manifold_pressure <= {r_map, 8'b0};
			throttle_position <= 23'(r_tps) * 23'(SCALE_TPS);
			coolant_temp      <= $signed(clt_w);
			intake_air_temp   <= $signed(iat_w);
			oxygen_sensor     <= 25'(r_o2) * 25'(SCALE_O2);
			spark_advance     <= {r_spk, 15'b0};
			fuel_pulse_one    <= 23'(r_inj1) * 23'(SCALE_INJ);
			fuel_pulse_two    <= 23'(r_inj2) * 23'(SCALE_INJ);
			battery_voltage   <= 25'(r_batt) * 25'(SCALE_BATT);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ecu_telemetry_frame_decoder.sv =====
// ECU telemetry frame decoder: top level
//
// Input channel (in_valid / in_stall): one received byte per beat, or a
// drained marker (drained = 1, rx_byte ignored) when the receive buffer
// has been flushed. Bytes are collected into 27-byte frames; the first
// five must carry the sync, length and service codes.
// Output channel (out_valid / out_stall): one beat of ten Q16.16 readings
// per good frame. A bad header drops the frame and every later byte until
// a drained marker arrives.
// The result passes from the frame's last byte through the frame stage,
// then the result register. Throughput: one byte per cycle while
// in_stall is low, set by the single frame stage between the byte store
// and the result register.
// A stalled receiver holds the result; one more frame can finish into the
// frame stage, after which in_stall rises until the result is taken.
// Bytes that do not end a frame are then also held off.
// Reset (arst_n low) clears the byte position, the discard flag and both
// valid flags; the byte store itself is not cleared.
`default_nettype none

module ecu_telemetry_frame_decoder
	import etfd_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          drained,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [29:0]        engine_speed,
	output logic [23:0]        manifold_pressure,
	output logic [22:0]        throttle_position,
	output logic signed [32:0] coolant_temp,
	output logic signed [32:0] intake_air_temp,
	output logic [24:0]        oxygen_sensor,
	output logic [30:0]        spark_advance,
	output logic [22:0]        fuel_pulse_one,
	output logic [22:0]        fuel_pulse_two,
	output logic [24:0]        battery_voltage
);

	frame_t frame_s1;
	logic   take;

	etfd_collect u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.drained  (drained),
		.take     (take),
		.frame_s1 (frame_s1)
	);

	etfd_scale u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.frame_s1          (frame_s1),
		.take              (take),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.engine_speed      (engine_speed),
		.manifold_pressure (manifold_pressure),
		.throttle_position (throttle_position),
		.coolant_temp      (coolant_temp),
		.intake_air_temp   (intake_air_temp),
		.oxygen_sensor     (oxygen_sensor),
		.spark_advance     (spark_advance),
		.fuel_pulse_one    (fuel_pulse_one),
		.fuel_pulse_two    (fuel_pulse_two),
		.battery_voltage   (battery_voltage)
	);

endmodule

`default_nettype wire
